### sv/evcp_pkg.sv
// Shared types, codes and helpers of the control pilot controller.
// No dependencies.
`default_nettype none

package evcp_pkg;

	// pilot states as reported on the result channel
	localparam logic [2:0] ST_DIS = 3'd0;
	localparam logic [2:0] ST_A   = 3'd1;
	localparam logic [2:0] ST_B   = 3'd2;
	localparam logic [2:0] ST_C   = 3'd3;
	localparam logic [2:0] ST_D   = 3'd4;
	localparam logic [2:0] ST_E   = 3'd5;
	localparam logic [2:0] ST_F   = 3'd6;
	localparam logic [2:0] ST_DF  = 3'd7;

	// item function codes
	localparam logic [3:0] FN_TICK    = 4'd0;
	localparam logic [3:0] FN_PWM_ON  = 4'd1;
	localparam logic [3:0] FN_PWM_OFF = 4'd2;
	localparam logic [3:0] FN_PWM_F   = 4'd3;
	localparam logic [3:0] FN_ENABLE  = 4'd4;
	localparam logic [3:0] FN_DISABLE = 4'd5;
	localparam logic [3:0] FN_REPLUG  = 4'd6;
	localparam logic [3:0] FN_ALLOW   = 4'd7;
	localparam logic [3:0] FN_3PH     = 4'd8;
	localparam logic [3:0] FN_OC      = 4'd9;
	localparam logic [3:0] FN_LOCK    = 4'd10;

	localparam logic [1:0] RELAY_OFF    = 2'd0;
	localparam logic [1:0] RELAY_SINGLE = 2'd1;
	localparam logic [1:0] RELAY_THREE  = 2'd2;

	localparam logic [1:0] LOCK_OFF    = 2'd0;
	localparam logic [1:0] LOCK_LOCK   = 2'd1;
	localparam logic [1:0] LOCK_UNLOCK = 2'd2;

	localparam logic [1:0] RP_IDLE  = 2'd0;
	localparam logic [1:0] RP_START = 2'd1;
	localparam logic [1:0] RP_F     = 2'd2;
	localparam logic [1:0] RP_HI    = 2'd3;

	localparam logic [1:0] CFG_TOL  = 2'd0;
	localparam logic [1:0] CFG_STOP = 2'd1;
	localparam logic [1:0] CFG_LOCK = 2'd2;

	localparam logic [11:0] TOL_RESET  = 12'd1100;
	localparam logic [15:0] STOP_RESET = 16'd7000;
	localparam logic [13:0] LOCK_RESET = 14'd1000;

	localparam logic [9:0] DUTY_HIGH = 10'd1010;
	localparam logic [9:0] DUTY_LOW  = 10'd0;

	// nominal pilot levels, mV
	localparam logic signed [17:0] NOM_12P = 18'sd12000;
	localparam logic signed [17:0] NOM_9P  = 18'sd9000;
	localparam logic signed [17:0] NOM_6P  = 18'sd6000;
	localparam logic signed [17:0] NOM_3P  = 18'sd3000;
	localparam logic signed [17:0] NOM_0   = 18'sd0;
	localparam logic signed [17:0] NOM_12N = -18'sd12000;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [14:0] cp_hi_mv;
		logic signed [14:0] cp_lo_mv;
		logic               sample_ready;
		logic               rcd_fired;
		logic [31:0]        arg_value;
		logic               arg_flag;
	} req_item_t;

	typedef struct packed {
		logic [2:0] pilot_state;
		logic [9:0] pwm_duty_pm;
		logic       pilot_driver_on;
		logic [1:0] relay_mode;
		logic       rcd_armed;
		logic [1:0] lock_motor;
		logic       diode_error;
		logic       rcd_error;
		logic       oc_error;
		logic       reading_valid;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]         cur;
		logic               pwm_run;
		logic               prev_pwm;
		logic [9:0]         duty;
		logic               pwr_ok;
		logic               tp_req;
		logic               tp_conf;
		logic [1:0]         rp_phase;
		logic signed [32:0] rp_tf;
		logic signed [32:0] rp_th;
		logic [31:0]        stop_tmr;
		logic               stop_armed;
		logic [15:0]        stop_lim;
		logic [31:0]        lock_tmr;
		logic               lock_armed;
		logic               oc_present;
		logic [31:0]        oc_elapsed;
		logic               oc_armed;
		logic [31:0]        oc_limit;
		logic               err_diode;
		logic               err_rcd;
		logic               err_oc;
		logic [1:0]         relay;
		logic [1:0]         lock_mot;
		logic               driver_en;
	} ctl_state_t;

	localparam ctl_state_t CTL_RESET = '{
		cur: ST_A, pwm_run: 1'b0, prev_pwm: 1'b0, duty: DUTY_HIGH, pwr_ok: 1'b0,
		tp_req: 1'b0, tp_conf: 1'b0, rp_phase: RP_IDLE, rp_tf: '0, rp_th: '0,
		stop_tmr: '0, stop_armed: 1'b0, stop_lim: '0, lock_tmr: '0,
		lock_armed: 1'b0, oc_present: 1'b0, oc_elapsed: '0, oc_armed: 1'b0,
		oc_limit: '0, err_diode: 1'b0, err_rcd: 1'b0, err_oc: 1'b0,
		relay: RELAY_OFF, lock_mot: LOCK_OFF, driver_en: 1'b1
	};

	// open band: center - tol < v < center + tol
	function automatic logic in_band(logic signed [17:0] v, logic signed [17:0] c,
			logic [11:0] tol);
		logic signed [17:0] t;
		t = $signed({6'd0, tol});
		return (v > c - t) && (v < c + t);
	endfunction

endpackage

`default_nettype wire

### sv/evcp_if.sv
// Valid/ready channel interfaces of the control pilot controller:
// command/tick items, result items and register writes. No dependencies.
`default_nettype none

interface evcp_req_if ();
	logic               valid;
	logic               ready;
	logic [3:0]         func;
	logic signed [14:0] cp_hi_mv;
	logic signed [14:0] cp_lo_mv;
	logic               sample_ready;
	logic               rcd_fired;
	logic [31:0]        arg_value;
	logic               arg_flag;

	modport source (output valid, func, cp_hi_mv, cp_lo_mv, sample_ready, rcd_fired,
		arg_value, arg_flag, input ready);
	modport sink (input valid, func, cp_hi_mv, cp_lo_mv, sample_ready, rcd_fired,
		arg_value, arg_flag, output ready);
endinterface

interface evcp_rsp_if ();
	logic       valid;
	logic       ready;
	logic [2:0] pilot_state;
	logic [9:0] pwm_duty_pm;
	logic       pilot_driver_on;
	logic [1:0] relay_mode;
	logic       rcd_armed;
	logic [1:0] lock_motor;
	logic       diode_error;
	logic       rcd_error;
	logic       oc_error;
	logic       reading_valid;

	modport source (output valid, pilot_state, pwm_duty_pm, pilot_driver_on, relay_mode,
		rcd_armed, lock_motor, diode_error, rcd_error, oc_error, reading_valid,
		input ready);
	modport sink (input valid, pilot_state, pwm_duty_pm, pilot_driver_on, relay_mode,
		rcd_armed, lock_motor, diode_error, rcd_error, oc_error, reading_valid,
		output ready);
endinterface

interface evcp_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/ev_control_pilot_controller.sv
// Top level of the control pilot controller: input register, state update, result register.
// Depends on evcp_pkg and the channel interfaces in evcp_if.sv.
`default_nettype none

// Takes one tick or command item per clock while the result channel is not stalled. An
// accepted item is held in an input register; from there the pilot classification and
// state rules update the controller state in a single pass and load the result register,
// which offers the result; while results are taken, one result follows each clock. The
// rate is set by the one state-update path, which every item passes once. req.ready drops
// only while a result waits untaken and another item sits in the input register. Register
// writes are always taken and should be made while no item is in flight. The stop, lock
// and overcurrent timers advance TICK_MS per tick while armed and saturate at 2^32-1.
module ev_control_pilot_controller import evcp_pkg::*; #(
	parameter int TICK_MS = 50
) (
	input  wire         clk,
	input  wire         arst_n,
	evcp_req_if.sink    req,
	evcp_rsp_if.source  rsp,
	evcp_cfg_if.sink    cfg
);

	localparam logic [31:0]        TICK_U = 32'(TICK_MS);
	localparam logic signed [32:0] TICK_S = 33'(TICK_MS);

	req_item_t  item_s1;
	logic       valid_s1;
	rsp_item_t  rsp_s2;
	logic       rsp_valid_q;
	ctl_state_t st_q;
	ctl_state_t st_d;
	rsp_item_t  rsp_d;
	logic       advance;

	logic [11:0] tol_q;
	logic [15:0] stop_to_q;
	logic [13:0] lock_run_q;

	function automatic logic [31:0] sat_add(logic [31:0] a);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, TICK_U};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic ctl_state_t arm_lock(ctl_state_t s);
		ctl_state_t r;
		r = s;
		r.lock_armed = 1'b1;
		r.lock_tmr = '0;
		return r;
	endfunction

	function automatic ctl_state_t pwm_off(ctl_state_t s);
		ctl_state_t r;
		r = s;
		r.duty = DUTY_HIGH;
		r.pwm_run = 1'b0;
		r.pwr_ok = 1'b0;
		return r;
	endfunction

	function automatic ctl_state_t pwm_f(ctl_state_t s);
		ctl_state_t r;
		r = s;
		r.duty = DUTY_LOW;
		r.cur = ST_F;
		r.pwm_run = 1'b0;
		r.pwr_ok = 1'b0;
		return r;
	endfunction

	function automatic ctl_state_t do_enable(ctl_state_t s);
		ctl_state_t r;
		r = pwm_off(s);
		r.cur = ST_A;
		r.driver_en = 1'b1;
		return r;
	endfunction

	function automatic ctl_state_t do_disable(ctl_state_t s);
		ctl_state_t r;
		r = pwm_off(s);
		r.cur = ST_DIS;
		r.driver_en = 1'b0;
		return r;
	endfunction

	function automatic ctl_state_t relay_on(ctl_state_t s, logic three);
		ctl_state_t r;
		r = s;
		if (s.relay == RELAY_OFF) begin
			if (!s.err_rcd) r.relay = three ? RELAY_THREE : RELAY_SINGLE;
			r = arm_lock(r);
		end
		return r;
	endfunction

	function automatic ctl_state_t relay_off(ctl_state_t s);
		ctl_state_t r;
		r = s;
		if (s.relay != RELAY_OFF) begin
			r.relay = RELAY_OFF;
			r = arm_lock(r);
		end
		return r;
	endfunction

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_comb begin
		ctl_state_t         n;
		logic               stable;
		logic signed [17:0] hi;
		logic signed [17:0] lo;
		logic signed [17:0] sum;
		logic signed [32:0] tnew;
		n = st_q;
		stable = 1'b0;
		hi = 18'(item_s1.cp_hi_mv);
		lo = 18'(item_s1.cp_lo_mv);
		sum = hi + lo;
		tnew = '0;
		case (item_s1.func)
			FN_TICK: begin
				if (n.stop_armed) n.stop_tmr = sat_add(n.stop_tmr);
				if (n.lock_armed) n.lock_tmr = sat_add(n.lock_tmr);
				if (n.oc_armed) n.oc_elapsed = sat_add(n.oc_elapsed);
				if (item_s1.rcd_fired) begin
					n.err_rcd = 1'b1;
					n.relay = RELAY_OFF;
				end
				if (n.lock_armed && n.lock_tmr > {18'd0, lock_run_q}) begin
					n.lock_mot = LOCK_OFF;
					n.lock_armed = 1'b0;
				end
				n.err_oc = n.oc_present && n.oc_armed && (n.oc_elapsed > n.oc_limit);
				if (item_s1.sample_ready) begin
					// classification; an unstable reading leaves the state as it was
					if (n.cur == ST_DIS) begin
						stable = 1'b1;
					end else if (in_band(hi, NOM_0, tol_q)) begin
						n.cur = ST_E;
						stable = 1'b1;
					end else if (n.pwm_run && !in_band(lo, NOM_12N, tol_q)) begin
						if (in_band(sum, NOM_0, tol_q)) begin
							n.cur = ST_DF;
							stable = 1'b1;
						end
					end else if (in_band(hi, NOM_12P, tol_q)) begin
						n.cur = ST_A;
						stable = 1'b1;
					end else if (in_band(hi, NOM_9P, tol_q)) begin
						n.cur = ST_B;
						stable = 1'b1;
					end else if (in_band(hi, NOM_6P, tol_q)) begin
						n.cur = ST_C;
						stable = 1'b1;
					end else if (in_band(hi, NOM_3P, tol_q)) begin
						n.cur = ST_D;
						stable = 1'b1;
					end else if (in_band(hi, NOM_12N, tol_q)) begin
						n.cur = ST_F;
						stable = 1'b1;
					end
				end
				if (stable) begin
					// replug: F for the set time, then disabled, then enabled again
					if (n.rp_phase == RP_START) begin
						n.rp_phase = RP_F;
						n = pwm_f(n);
					end
					if (n.rp_phase == RP_F) begin
						tnew = n.rp_tf - TICK_S;
						n.rp_tf = tnew;
						if (tnew[32] || tnew == '0) begin
							n = do_disable(n);
							n.rp_phase = RP_HI;
						end
					end
					if (n.rp_phase == RP_HI) begin
						tnew = n.rp_th - TICK_S;
						n.rp_th = tnew;
						if (tnew[32] || tnew == '0) begin
							n = do_enable(n);
							n.rp_phase = RP_IDLE;
						end
					end
					n.err_diode = 1'b0;
					case (n.cur)
						ST_DIS: begin
							n.pwr_ok = 1'b0;
							n = relay_off(n);
						end
						ST_A: begin
							n.tp_conf = n.tp_req;
							n.err_rcd = 1'b0;
							n = pwm_off(n);
							n = relay_off(n);
						end
						ST_B: n = relay_off(n);
						ST_C, ST_D: begin
							if (!n.pwm_run) begin
								// PWM just stopped: start the forced power-off timer
								if (n.prev_pwm) begin
									n.stop_armed = 1'b1;
									n.stop_tmr = '0;
									n.stop_lim = stop_to_q;
								end
								if (n.stop_armed && n.stop_tmr > {16'd0, n.stop_lim})
									n = relay_off(n);
							end else if (n.pwr_ok) begin
								n = relay_on(n, n.tp_conf);
							end
						end
						ST_E, ST_F: begin
							n = relay_off(n);
							n = pwm_off(n);
						end
						default: begin
							n.err_diode = 1'b1;
							n = relay_off(n);
						end
					endcase
					n.prev_pwm = n.pwm_run;
				end
			end
			FN_PWM_ON: begin
				n.duty = (item_s1.arg_value > {22'd0, DUTY_HIGH}) ? DUTY_HIGH
					: item_s1.arg_value[9:0];
				n.pwm_run = 1'b1;
			end
			FN_PWM_OFF: n = pwm_off(n);
			FN_PWM_F:   n = pwm_f(n);
			FN_ENABLE:  n = do_enable(n);
			FN_DISABLE: n = do_disable(n);
			FN_REPLUG: begin
				n.rp_tf = $signed({1'b0, item_s1.arg_value});
				n.rp_th = $signed({1'b0, item_s1.arg_value});
				n.rp_phase = RP_START;
			end
			FN_ALLOW: n.pwr_ok = item_s1.arg_flag;
			FN_3PH:   n.tp_req = item_s1.arg_flag;
			FN_OC: begin
				n.oc_limit = item_s1.arg_value;
				if (!n.oc_present && item_s1.arg_flag) begin
					n.oc_armed = 1'b1;
					n.oc_elapsed = '0;
				end
				n.oc_present = item_s1.arg_flag;
			end
			FN_LOCK: begin
				n.lock_mot = item_s1.arg_flag ? LOCK_LOCK : LOCK_UNLOCK;
				n = arm_lock(n);
			end
			default: ;
		endcase
		st_d = n;
		rsp_d.pilot_state     = n.cur;
		rsp_d.pwm_duty_pm     = n.duty;
		rsp_d.pilot_driver_on = n.driver_en;
		rsp_d.relay_mode      = n.relay;
		rsp_d.rcd_armed       = (n.relay != RELAY_OFF);
		rsp_d.lock_motor      = n.lock_mot;
		rsp_d.diode_error     = n.err_diode;
		rsp_d.rcd_error       = n.err_rcd;
		rsp_d.oc_error        = n.err_oc;
		rsp_d.reading_valid   = stable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			st_q        <= CTL_RESET;
			tol_q       <= TOL_RESET;
			stop_to_q   <= STOP_RESET;
			lock_run_q  <= LOCK_RESET;
		end else begin
			if (req.ready) valid_s1 <= req.valid;
			if (valid_s1 && advance) begin
				st_q        <= st_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_TOL:  tol_q      <= cfg.data[11:0];
					CFG_STOP: stop_to_q  <= cfg.data;
					CFG_LOCK: lock_run_q <= cfg.data[13:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func         <= req.func;
			item_s1.cp_hi_mv     <= req.cp_hi_mv;
			item_s1.cp_lo_mv     <= req.cp_lo_mv;
			item_s1.sample_ready <= req.sample_ready;
			item_s1.rcd_fired    <= req.rcd_fired;
			item_s1.arg_value    <= req.arg_value;
			item_s1.arg_flag     <= req.arg_flag;
		end
		if (valid_s1 && advance) rsp_s2 <= rsp_d;
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.pilot_state     = rsp_s2.pilot_state;
	assign rsp.pwm_duty_pm     = rsp_s2.pwm_duty_pm;
	assign rsp.pilot_driver_on = rsp_s2.pilot_driver_on;
	assign rsp.relay_mode      = rsp_s2.relay_mode;
	assign rsp.rcd_armed       = rsp_s2.rcd_armed;
	assign rsp.lock_motor      = rsp_s2.lock_motor;
	assign rsp.diode_error     = rsp_s2.diode_error;
	assign rsp.rcd_error       = rsp_s2.rcd_error;
	assign rsp.oc_error        = rsp_s2.oc_error;
	assign rsp.reading_valid   = rsp_s2.reading_valid;

	// a latched RCD trip keeps the contactor open
	a_rcd_relay: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.err_rcd |-> (st_q.relay == RELAY_OFF))
		else $error("relay closed while RCD error latched");

	// only a tick can yield a classified reading
	a_valid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && item_s1.func != FN_TICK) |=> !rsp.reading_valid)
		else $error("reading_valid on a command item");

	// input stalls only behind an untaken result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (rsp.valid && !rsp.ready && valid_s1))
		else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire
